### src/ascc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascc_pkg
// Shared types, widths, codes and constant tables of the step-size controller.
// ----------------------------------------------------------------------------
package ascc_pkg;

  localparam int TIME_FRAC_BITS = 32;
  localparam int ERR_FRAC_BITS  = 16;
  localparam int COUNT_WIDTH    = 32;
  localparam int FAC_FRAC_BITS  = 24;

  localparam int TIME_W    = 48;
  localparam int ERR_W     = 32;
  localparam int FAC_W     = 32;
  localparam int EXPN_W    = 16;
  localparam int LOG_W     = 32;
  localparam int SUM_W     = 48;
  localparam int RATIO_W   = 62;
  localparam int DATA_W    = 48;
  localparam int CFG_IDX_W = 4;
  localparam int DVD_W     = TIME_W + FAC_FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int ROOT_W    = 31;
  localparam int ITER_N    = 24;

  localparam longint unsigned ONE_TIME = 64'd1 << TIME_FRAC_BITS;
  localparam longint unsigned FLOOR_RAW = ((64'd1 << ERR_FRAC_BITS) + 64'd5000) / 64'd10000;

  localparam logic [TIME_W-1:0] INIT_STEP_RST  = TIME_W'((ONE_TIME + 64'd500) / 64'd1000);
  localparam logic [TIME_W-1:0] FINAL_TIME_RST = TIME_W'(ONE_TIME * 64'd10);
  localparam logic [TIME_W-1:0] MIN_STEP_RST   =
    TIME_W'((ONE_TIME + 64'd50000000) / 64'd100000000);
  localparam logic [FAC_W-1:0]  SAFETY_RST     = 32'd13421773;
  localparam logic [EXPN_W-1:0] BETA_RST       = 16'd3277;
  localparam logic [EXPN_W-1:0] ERR_EXP_RST    = 16'd13926;
  localparam logic [FAC_W-1:0]  SHRINK_RST     = 32'd83886080;
  localparam logic [FAC_W-1:0]  GROW_RST       = 32'd3355443;
  localparam logic [ERR_W-1:0]  ERR_FLOOR      = (FLOOR_RAW == 0) ? ERR_W'(1) : ERR_W'(FLOOR_RAW);

  localparam logic [TIME_W-1:0]  TIME_MAX = '1;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_HALT = 2'd1,
    STATUS_SAT  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_STEP   = 4'd0,
    REG_FINAL_TIME     = 4'd1,
    REG_MIN_STEP       = 4'd2,
    REG_SAFETY_FACTOR  = 4'd3,
    REG_BETA_EXPONENT  = 4'd4,
    REG_ERROR_EXPONENT = 4'd5,
    REG_SHRINK_LIMIT   = 4'd6,
    REG_GROW_LIMIT     = 4'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_LOG, S_LOG_WAIT, S_PROD, S_SUM, S_EXP, S_EXP_WAIT,
    S_SHIFT, S_RATIO, S_DIV, S_DIV_WAIT, S_COMMIT, S_CLIP, S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic start_run;
    logic log_start;
    logic prod;
    logic sum;
    logic exp_start;
    logic exp_shift;
    logic ratio;
    logic div_start;
    logic commit;
    logic clip;
    logic out_load;
  } ascc_cmd_t;

  typedef struct packed {
    logic log_done;
    logic exp_done;
    logic div_done;
    logic halted;
  } ascc_sts_t;

  typedef logic [ITER_N-1:0][ROOT_W-1:0] root_tbl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    x    = x_in;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bitv > x) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (x >= res + bitv) begin
          x   = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // Entry k holds 2^(2^-(k+1)) in Q1.30, each root taken from the one before.
  function automatic root_tbl_t build_roots();
    logic [63:0] r;
    root_tbl_t   t;
    r = 64'd1 << 31;
    for (int k = 0; k < ITER_N; k++) begin
      r    = isqrt64(r << 30);
      t[k] = r[ROOT_W-1:0];
    end
    return t;
  endfunction

  localparam root_tbl_t EXP2_ROOTS = build_roots();

endpackage

### src/ascc_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascc_log2
// Iterative base-2 logarithm: 24 truncating squaring rounds, one per cycle.
// ----------------------------------------------------------------------------
module ascc_log2 import ascc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [ERR_W-1:0]        x,
  input  logic [4:0]              frac_bits,
  output logic                    done,
  output logic signed [LOG_W-1:0] result
);

  logic [4:0]          p;
  logic [ERR_W-1:0]    x_sh;
  logic [ROOT_W-1:0]   m_init;
  logic [ROOT_W-1:0]   m;
  logic [ROOT_W-1:0]   m_next;
  logic [2*ROOT_W-1:0] sq;
  logic [ERR_W-1:0]    t;
  logic [ITER_N-1:0]   fr;
  logic [7:0]          dif;
  logic [4:0]          cnt;
  logic                busy;

  always_comb begin
    p = '0;
    for (int i = 0; i < ERR_W; i++) begin
      if (x[i]) p = 5'(i);
    end
    x_sh = x << (5'd30 - p);
    m_init = (p == 5'd31) ? x[ERR_W-1:1] : x_sh[ROOT_W-1:0];
  end

  assign sq     = m * m;
  assign t      = sq[2*ROOT_W-1:30];
  assign m_next = t[ERR_W-1] ? t[ERR_W-1:1] : t[ROOT_W-1:0];
  assign result = {dif, fr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        m    <= m_init;
        fr   <= '0;
        dif  <= {3'b0, p} - {3'b0, frac_bits};
      end else if (busy) begin
        m   <= m_next;
        fr  <= {fr[ITER_N-2:0], t[ERR_W-1]};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(ITER_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/ascc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascc_dp
// Datapath: configuration, run state, log/exp/divide units and output register.
// ----------------------------------------------------------------------------
module ascc_dp import ascc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  ascc_cmd_t              cmd,
  output ascc_sts_t              sts,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  input  logic                   func,
  input  logic [ERR_W-1:0]       error_estimate,
  output logic [TIME_W-1:0]      next_step,
  output logic [TIME_W-1:0]      sim_time,
  output logic                   accepted,
  output logic                   finished,
  output logic [1:0]             status,
  output logic [COUNT_WIDTH-1:0] accepted_steps,
  output logic [COUNT_WIDTH-1:0] rejected_steps
);

  // Configuration registers.
  logic [TIME_W-1:0] initial_step, final_time, min_step;
  logic [FAC_W-1:0]  safety_factor, shrink_limit, grow_limit;
  logic [EXPN_W-1:0] beta_exponent, error_exponent;

  // Run state.
  logic [TIME_W-1:0]      step_size, current_time;
  logic [ERR_W-1:0]       previous_error;
  logic                   finish_flag, halt_flag;
  logic [COUNT_WIDTH-1:0] accept_count, reject_count;

  // Per-request working registers.
  logic [ERR_W-1:0] e_reg, sf_eff;
  logic             acc_path, zero_pow, e_zero, did_report, sat;

  logic                    log_done_sf, log_done_e, log_done_p;
  logic signed [LOG_W-1:0] log_sf, log_e, log_p, le_eff;
  logic signed [SUM_W:0]   prod_e, prod_b;
  logic signed [SUM_W-1:0] pe, pb, pl, s_exp;

  logic [ROOT_W-1:0]       exp_acc;
  logic [2*ROOT_W-1:0]     exp_prod;
  logic [4:0]              exp_cnt;
  logic                    exp_busy, exp_done;
  logic [ITER_N-1:0]       exp_frac;
  logic signed [7:0]       exp_n;
  logic signed [8:0]       exp_rs;
  logic [RATIO_W-1:0]      acc_wide, exp_shl, exp_shr, exp_res;
  logic                    exp_sat;

  logic [RATIO_W-1:0]      shrink_w, grow_w, r0, r1, ratio;

  logic [RATIO_W-1:0]      rem;
  logic [RATIO_W:0]        trial;
  logic                    q_bit;
  logic [DVD_W-1:0]        dvd, quo;
  logic [DIV_CNT_W-1:0]    div_cnt;
  logic                    div_busy, div_done, div_zero, div_ovf;

  logic [TIME_W:0]         time_sum;
  logic [TIME_W-1:0]       time_left;

  ascc_log2 u_log_sf (
    .clk(clk), .rst(rst), .start(cmd.log_start), .x(sf_eff),
    .frac_bits(5'(FAC_FRAC_BITS)), .done(log_done_sf), .result(log_sf)
  );

  ascc_log2 u_log_e (
    .clk(clk), .rst(rst), .start(cmd.log_start), .x(e_reg),
    .frac_bits(5'(ERR_FRAC_BITS)), .done(log_done_e), .result(log_e)
  );

  ascc_log2 u_log_p (
    .clk(clk), .rst(rst), .start(cmd.log_start), .x(previous_error),
    .frac_bits(5'(ERR_FRAC_BITS)), .done(log_done_p), .result(log_p)
  );

  assign le_eff = e_zero ? '0 : log_e;
  assign prod_e = $signed({1'b0, error_exponent}) * le_eff;
  assign prod_b = $signed({1'b0, beta_exponent}) * log_p;

  // Exponent: integer part in the top byte, 24 fraction bits drive the roots.
  assign exp_frac = s_exp[39:16];
  assign exp_n    = s_exp[SUM_W-1:40];
  assign exp_prod = exp_acc * EXP2_ROOTS[exp_cnt];
  assign acc_wide = {{(RATIO_W-ROOT_W){1'b0}}, exp_acc};
  assign exp_shl  = acc_wide << 5'(exp_n - 8'sd6);
  assign exp_rs   = 9'sd6 - {exp_n[7], exp_n};
  assign exp_shr  = (exp_rs >= 9'sd31) ? '0 : (acc_wide >> exp_rs[4:0]);

  assign shrink_w = {{(RATIO_W-FAC_W){1'b0}}, shrink_limit};
  assign grow_w   = {{(RATIO_W-FAC_W){1'b0}}, grow_limit};
  assign r0       = zero_pow ? '0 : exp_res;
  assign r1       = (r0 > shrink_w) ? shrink_w : r0;

  assign trial = {rem, dvd[DVD_W-1]};
  assign q_bit = (trial >= {1'b0, ratio});

  assign time_sum  = {1'b0, current_time} + {1'b0, step_size};
  assign time_left = final_time - current_time;
  assign div_ovf   = (quo[DVD_W-1:TIME_W] != '0);

  assign sts.log_done = log_done_sf & log_done_e & log_done_p;
  assign sts.exp_done = exp_done;
  assign sts.div_done = div_done;
  assign sts.halted   = halt_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_step   <= INIT_STEP_RST;
      final_time     <= FINAL_TIME_RST;
      min_step       <= MIN_STEP_RST;
      safety_factor  <= SAFETY_RST;
      beta_exponent  <= BETA_RST;
      error_exponent <= ERR_EXP_RST;
      shrink_limit   <= SHRINK_RST;
      grow_limit     <= GROW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INITIAL_STEP:   initial_step   <= cfg_data[TIME_W-1:0];
        REG_FINAL_TIME:     final_time     <= cfg_data[TIME_W-1:0];
        REG_MIN_STEP:       min_step       <= cfg_data[TIME_W-1:0];
        REG_SAFETY_FACTOR:  safety_factor  <= cfg_data[FAC_W-1:0];
        REG_BETA_EXPONENT:  beta_exponent  <= cfg_data[EXPN_W-1:0];
        REG_ERROR_EXPONENT: error_exponent <= cfg_data[EXPN_W-1:0];
        REG_SHRINK_LIMIT:   shrink_limit   <= cfg_data[FAC_W-1:0];
        REG_GROW_LIMIT:     grow_limit     <= cfg_data[FAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size      <= '0;
      current_time   <= '0;
      previous_error <= ERR_FLOOR;
      finish_flag    <= 1'b0;
      halt_flag      <= 1'b0;
      accept_count   <= '0;
      reject_count   <= '0;
      exp_busy       <= 1'b0;
      exp_done       <= 1'b0;
      div_busy       <= 1'b0;
      div_done       <= 1'b0;
      sat            <= 1'b0;
    end else begin
      exp_done <= 1'b0;
      div_done <= 1'b0;

      if (cmd.capture) begin
        e_reg      <= error_estimate;
        e_zero     <= (error_estimate == '0);
        zero_pow   <= (error_estimate == '0) && (error_exponent != '0);
        acc_path   <= (error_estimate[ERR_W-1:ERR_FRAC_BITS] == '0);
        did_report <= (func == FUNC_REPORT) && !halt_flag;
        sf_eff     <= (safety_factor == '0) ? ERR_W'(1) : safety_factor;
        sat        <= (func == FUNC_REPORT) && (safety_factor == '0);
      end

      if (cmd.prod) begin
        pe <= prod_e[SUM_W-1:0];
        pb <= prod_b[SUM_W-1:0];
        pl <= {log_sf, 16'b0};
      end

      if (cmd.sum) begin
        s_exp <= acc_path ? (pe - pb - pl) : (pe - pl);
      end

      if (cmd.exp_start) begin
        exp_acc  <= ROOT_W'(1) << 30;
        exp_cnt  <= '0;
        exp_busy <= 1'b1;
      end else if (exp_busy) begin
        if (exp_frac[5'(ITER_N - 1) - exp_cnt]) exp_acc <= exp_prod[60:30];
        exp_cnt <= exp_cnt + 5'd1;
        if (exp_cnt == 5'(ITER_N - 1)) begin
          exp_busy <= 1'b0;
          exp_done <= 1'b1;
        end
      end

      if (cmd.exp_shift) begin
        if (exp_n > 8'sd37) begin
          exp_res <= RATIO_MAX;
          exp_sat <= 1'b1;
        end else begin
          exp_res <= (exp_n >= 8'sd6) ? exp_shl : exp_shr;
          exp_sat <= 1'b0;
        end
      end

      if (cmd.ratio) begin
        if (acc_path) begin
          ratio <= (r1 < grow_w) ? grow_w : r1;
        end else if (exp_res > shrink_w) begin
          ratio <= exp_res;
          if (exp_sat) sat <= 1'b1;
        end else begin
          ratio <= shrink_w;
        end
      end

      // Restoring division of step * 2^24 by the ratio, one quotient bit a cycle.
      if (cmd.div_start) begin
        dvd      <= {step_size, {FAC_FRAC_BITS{1'b0}}};
        rem      <= '0;
        quo      <= '0;
        div_cnt  <= '0;
        div_zero <= (ratio == '0);
        if (ratio == '0) begin
          div_done <= 1'b1;
        end else begin
          div_busy <= 1'b1;
        end
      end else if (div_busy) begin
        rem     <= q_bit ? RATIO_W'(trial - {1'b0, ratio}) : trial[RATIO_W-1:0];
        dvd     <= {dvd[DVD_W-2:0], 1'b0};
        quo     <= {quo[DVD_W-2:0], q_bit};
        div_cnt <= div_cnt + 1'b1;
        if (div_cnt == DIV_CNT_W'(DVD_W - 1)) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end

      if (cmd.commit) begin
        if (div_zero || div_ovf) begin
          step_size <= TIME_MAX;
          sat       <= 1'b1;
        end else begin
          step_size <= quo[TIME_W-1:0];
        end
        if (acc_path) begin
          if (time_sum[TIME_W]) begin
            current_time <= TIME_MAX;
            sat          <= 1'b1;
          end else begin
            current_time <= time_sum[TIME_W-1:0];
          end
          previous_error <= (e_reg > ERR_FLOOR) ? e_reg : ERR_FLOOR;
          if (accept_count != '1) accept_count <= accept_count + 1'b1;
        end else begin
          if (reject_count != '1) reject_count <= reject_count + 1'b1;
        end
      end

      if (cmd.start_run) begin
        step_size      <= initial_step;
        current_time   <= '0;
        previous_error <= ERR_FLOOR;
        accept_count   <= '0;
        reject_count   <= '0;
        halt_flag      <= 1'b0;
      end

      if (cmd.clip) begin
        if (step_size < min_step) begin
          halt_flag   <= 1'b1;
          finish_flag <= 1'b0;
        end else if (current_time >= final_time) begin
          step_size   <= '0;
          finish_flag <= 1'b1;
        end else if (step_size > time_left) begin
          step_size   <= time_left;
          finish_flag <= 1'b1;
        end else begin
          finish_flag <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      next_step      <= step_size;
      sim_time       <= current_time;
      accepted       <= did_report && acc_path;
      finished       <= finish_flag;
      status         <= halt_flag ? STATUS_HALT : (sat ? STATUS_SAT : STATUS_OK);
      accepted_steps <= accept_count;
      rejected_steps <= reject_count;
    end
  end

endmodule

### src/ascc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascc_ctrl
// Controller: sequences one request through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module ascc_ctrl import ascc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      func,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ascc_sts_t sts,
  output ascc_cmd_t cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (func == FUNC_START) begin
            state_next = S_START;
          end else if (sts.halted) begin
            state_next = S_OUT;
          end else begin
            state_next = S_LOG;
          end
        end
      end
      S_START: begin
        cmd.start_run = 1'b1;
        state_next    = S_CLIP;
      end
      S_LOG: begin
        cmd.log_start = 1'b1;
        state_next    = S_LOG_WAIT;
      end
      S_LOG_WAIT: begin
        if (sts.log_done) state_next = S_PROD;
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.exp_start = 1'b1;
        state_next    = S_EXP_WAIT;
      end
      S_EXP_WAIT: begin
        if (sts.exp_done) state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.exp_shift = 1'b1;
        state_next    = S_RATIO;
      end
      S_RATIO: begin
        cmd.ratio  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_CLIP;
      end
      S_CLIP: begin
        cmd.clip   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // The output register may only be refilled once the last result is gone.
        if (!(out_valid && out_stall)) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### src/adaptive_step_size_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_step_size_controller_unit
// Error-controlled step-size regulator for an embedded Runge-Kutta integrator.
// ----------------------------------------------------------------------------
// A request (func, error_estimate) is taken when in_valid is high and in_stall
// is low. A start request loads the initial step and clears time and counters;
// a report request carries the normalized error of the last attempted step.
// Every request yields one result (next step, time, flags, counters) on the
// out channel, held in an output register until out_valid meets a low
// out_stall. One request is processed at a time. The result register is loaded
// after a start request passes the start and clip states, and after a report
// request once the 24 squaring rounds of the log units, the 24 root
// multiplies of the exp unit and the 72-bit restoring divider are done. A
// report while halted goes straight from the idle state to the output state.
// The next request can be taken in the cycle after the result is loaded. The
// next request is taken while a finished result still waits in the output
// register; a stalled receiver only holds up the block once a second result
// is ready to be written.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are expected while the block is idle. Reset restores the default register
// values and clears time, step, counters and the halt flag.
// ----------------------------------------------------------------------------
module adaptive_step_size_controller_unit import ascc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   func,
  input  logic [ERR_W-1:0]       error_estimate,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [TIME_W-1:0]      next_step,
  output logic [TIME_W-1:0]      sim_time,
  output logic                   accepted,
  output logic                   finished,
  output logic [1:0]             status,
  output logic [COUNT_WIDTH-1:0] accepted_steps,
  output logic [COUNT_WIDTH-1:0] rejected_steps
);

  ascc_cmd_t cmd;
  ascc_sts_t sts;

  ascc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .func(func), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  ascc_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .func(func), .error_estimate(error_estimate),
    .next_step(next_step), .sim_time(sim_time), .accepted(accepted),
    .finished(finished), .status(status), .accepted_steps(accepted_steps),
    .rejected_steps(rejected_steps)
  );

  // One request at a time: after a request is taken the input side closes.
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({next_step, sim_time, accepted,
      finished, status, accepted_steps, rejected_steps}))
    else $error("stalled result changed");

  a_halt_not_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_HALT |-> !finished)
    else $error("halted result flagged as finished");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_OK || status == STATUS_HALT || status == STATUS_SAT))
    else $error("status code out of range");

endmodule
